// File: rtl/ffha_pkg.sv
// Shared types and codes for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

  localparam int MAX_CHUNKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 16;

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_BYTES = 2'd1;

  typedef struct packed {
    logic        used;
    logic [31:0] size;
    logic [31:0] hdr;
  } entry_t;

endpackage

// File: rtl/ffha_table.sv
// Chunk table memory: one write port, one registered read port.
// Depends on ffha_pkg.
module ffha_table #(
  parameter int DEPTH = ffha_pkg::MAX_CHUNKS_DEF,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic [IW-1:0]       rd_addr,
  output ffha_pkg::entry_t    rd_data,
  input  logic                we,
  input  logic [IW-1:0]       wr_addr,
  input  ffha_pkg::entry_t    wr_data
);

  ffha_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/first_fit_heap_allocator_unit.sv
// First-fit heap allocator top level: sequencer around the chunk table.
// Depends on ffha_pkg and ffha_table.
//
// One item at a time. An allocate scans the table, reading then evaluating each
// chunk, until the first fit, then moves later entries up one place (a read and a
// write each) on a split and writes one or two entries; a release scans the same
// way, reads the successor, then moves later entries down (a read and a write
// each) on a merge. A config write passes through S_INIT before the unit is idle
// again. The result appears for one cycle with done high and cannot be stalled;
// busy stays high until that cycle ends.
module first_fit_heap_allocator_unit #(
  parameter int MAX_CHUNKS   = ffha_pkg::MAX_CHUNKS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [31:0] req_size,
  input  logic [31:0] block_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [31:0] grant_addr,
  output logic [1:0]  status
);

  localparam int IW = $clog2(MAX_CHUNKS);
  localparam int CW = $clog2(MAX_CHUNKS + 1);
  localparam logic [31:0] HB = 32'(HEADER_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_RD, S_EV, S_NRD, S_NEV, S_RDEC, S_MRD, S_MWR, S_W1, S_W2, S_DONE
  } state_t;

  state_t state;
  logic [31:0] heap_base, heap_bytes;
  logic [CW-1:0] cnt;
  logic [IW-1:0] idx, k, src, mv_end, w1_idx, w2_idx;
  logic op;
  logic [31:0] req, rel_hdr;
  logic p_used, n_ok, n_used, mv_up, mv_two, w2_en;
  logic [31:0] p_size, p_hdr, c_size, c_hdr, n_size;
  ffha_pkg::entry_t w1_data, w2_data;

  ffha_pkg::entry_t rd_data, wr_data;
  logic we;
  logic [IW-1:0] rd_addr, wr_addr, dst;

  ffha_table #(.DEPTH(MAX_CHUNKS), .IW(IW)) u_table (
    .clk(clk), .rd_addr(rd_addr), .rd_data(rd_data),
    .we(we), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;
  assign done      = (state == S_DONE);
  assign rd_addr   = (state == S_MRD) ? src : idx;
  assign dst       = mv_up ? IW'(src + IW'(1)) : (mv_two ? IW'(src - IW'(2)) : IW'(src - IW'(1)));

  always_comb begin
    we = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      S_INIT: begin
        we = (cnt != '0);
        wr_data.hdr = heap_base;
        wr_data.size = heap_bytes - HB;
      end
      S_MWR: begin
        we = 1'b1;
        wr_addr = dst;
        wr_data = rd_data;
      end
      S_W1: begin
        we = 1'b1;
        wr_addr = w1_idx;
        wr_data = w1_data;
      end
      S_W2: begin
        we = 1'b1;
        wr_addr = w2_idx;
        wr_data = w2_data;
      end
      default: we = 1'b0;
    endcase
  end

  logic fit, hit, last, split;
  logic [32:0] need;
  assign fit   = !rd_data.used && (rd_data.size > req);
  assign hit   = (rd_data.hdr == rel_hdr);
  assign last  = ((CW+1)'(idx) + (CW+1)'(1)) >= (CW+1)'(cnt);
  assign need  = {1'b0, req} + {1'b0, HB} + 33'd1;
  assign split = ({1'b0, rd_data.size} >= need) && (cnt < CW'(MAX_CHUNKS));

  logic pm, nm;
  assign pm = (k != '0) && !p_used;
  assign nm = n_ok && !n_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      heap_base <= '0;
      heap_bytes <= '0;
      cnt <= '0;
      idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op <= func;
            req <= req_size;
            rel_hdr <= block_addr - HB;
            idx <= '0;
            p_used <= 1'b1;
            grant_addr <= '0;
            if (cnt == '0) begin
              status <= (func == ffha_pkg::FN_ALLOC) ? ffha_pkg::ST_NOFIT
                                                      : ffha_pkg::ST_UNKNOWN;
              state <= S_DONE;
            end else begin
              state <= S_RD;
            end
          end else if (cfg_valid) begin
            if (cfg_index == ffha_pkg::REG_BASE) begin
              heap_base <= cfg_data;
              cnt <= (heap_bytes >= HB) ? CW'(1) : '0;
              state <= S_INIT;
            end else if (cfg_index == ffha_pkg::REG_BYTES) begin
              heap_bytes <= cfg_data;
              cnt <= (cfg_data >= HB) ? CW'(1) : '0;
              state <= S_INIT;
            end
          end
        end
        S_INIT: state <= S_IDLE;
        S_RD: state <= S_EV;
        S_EV: begin
          if (op == ffha_pkg::FN_ALLOC && fit) begin
            grant_addr <= rd_data.hdr + HB;
            status <= ffha_pkg::ST_OK;
            w1_idx <= idx;
            w1_data.used <= 1'b1;
            w1_data.hdr <= rd_data.hdr;
            mv_up <= 1'b1;
            mv_two <= 1'b0;
            src <= IW'(cnt - CW'(1));
            mv_end <= IW'(idx + IW'(1));
            if (split) begin
              w1_data.size <= req;
              w2_en <= 1'b1;
              w2_idx <= IW'(idx + IW'(1));
              w2_data.used <= 1'b0;
              w2_data.size <= rd_data.size - req - HB;
              w2_data.hdr <= rd_data.hdr + HB + req;
              cnt <= cnt + CW'(1);
              state <= last ? S_W1 : S_MRD;
            end else begin
              w1_data.size <= rd_data.size;
              w2_en <= 1'b0;
              state <= S_W1;
            end
          end else if (op == ffha_pkg::FN_FREE && hit) begin
            k <= idx;
            c_size <= rd_data.size;
            c_hdr <= rd_data.hdr;
            status <= ffha_pkg::ST_OK;
            n_ok <= !last;
            idx <= IW'(idx + IW'(1));
            state <= last ? S_RDEC : S_NRD;
          end else if (last) begin
            status <= (op == ffha_pkg::FN_ALLOC) ? ffha_pkg::ST_NOFIT
                                                  : ffha_pkg::ST_UNKNOWN;
            state <= S_DONE;
          end else begin
            p_used <= rd_data.used;
            p_size <= rd_data.size;
            p_hdr <= rd_data.hdr;
            idx <= IW'(idx + IW'(1));
            state <= S_RD;
          end
        end
        S_NRD: state <= S_NEV;
        S_NEV: begin
          n_used <= rd_data.used;
          n_size <= rd_data.size;
          state <= S_RDEC;
        end
        S_RDEC: begin
          w2_en <= 1'b0;
          mv_up <= 1'b0;
          mv_end <= IW'(cnt - CW'(1));
          w1_data.used <= 1'b0;
          priority if (pm && nm) begin
            w1_idx <= IW'(k - IW'(1));
            w1_data.size <= p_size + c_size + n_size + HB + HB;
            w1_data.hdr <= p_hdr;
            mv_two <= 1'b1;
            src <= IW'(k + IW'(2));
            cnt <= cnt - CW'(2);
            state <= (((CW+1)'(k) + (CW+1)'(2)) < (CW+1)'(cnt)) ? S_MRD : S_W1;
          end else if (pm) begin
            w1_idx <= IW'(k - IW'(1));
            w1_data.size <= p_size + c_size + HB;
            w1_data.hdr <= p_hdr;
            mv_two <= 1'b0;
            src <= IW'(k + IW'(1));
            cnt <= cnt - CW'(1);
            state <= (((CW+1)'(k) + (CW+1)'(1)) < (CW+1)'(cnt)) ? S_MRD : S_W1;
          end else if (nm) begin
            w1_idx <= k;
            w1_data.size <= c_size + n_size + HB;
            w1_data.hdr <= c_hdr;
            mv_two <= 1'b0;
            src <= IW'(k + IW'(2));
            cnt <= cnt - CW'(1);
            state <= (((CW+1)'(k) + (CW+1)'(2)) < (CW+1)'(cnt)) ? S_MRD : S_W1;
          end else begin
            w1_idx <= k;
            w1_data.size <= c_size;
            w1_data.hdr <= c_hdr;
            mv_two <= 1'b0;
            state <= S_W1;
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          if (src == mv_end) begin
            state <= S_W1;
          end else begin
            src <= mv_up ? IW'(src - IW'(1)) : IW'(src + IW'(1));
            state <= S_MRD;
          end
        end
        S_W1: state <= w2_en ? S_W2 : S_DONE;
        S_W2: state <= S_DONE;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ffha_checker.sv
// Port-level checks for first_fit_heap_allocator_unit, and the bind that attaches them.
// Depends on ffha_pkg and the top level's ports.
module ffha_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] grant_addr,
  input logic [1:0]  status
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result outside an item");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ffha_pkg::ST_OK |-> grant_addr == '0)
    else $error("failed item returned an address");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status != 2'd3) else $error("undefined status");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .grant_addr(grant_addr), .status(status)
);
